@@ hdl/union_find_engine_assert.svh @@
// Assertion macros shared by the union-find engine RTL.
`ifndef UNION_FIND_ENGINE_ASSERT_SVH
`define UNION_FIND_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define UFE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("union_find_engine: assertion failed");
`define UFE_NEVER(lbl, expr) `UFE_ASSERT(lbl, !(expr))
`else
`define UFE_ASSERT(lbl, prop)
`define UFE_NEVER(lbl, expr)
`endif
`endif

@@ hdl/ufe_pkg.sv @@
// Package: field widths and defaults of the union-find engine.
`timescale 1ns / 1ps
package ufe_pkg;
	localparam int UFE_MAX_NODES = 1024;
	localparam int NODE_W        = 10;
	localparam int COUNT_W       = 11;
	localparam int IN_DATA_W     = 24;
	localparam int OUT_DATA_W    = 16;
	localparam int OUT_PAD_W     = OUT_DATA_W - 1 - COUNT_W;
	localparam int IN_PAD_W      = IN_DATA_W - 2 * NODE_W;
endpackage

@@ hdl/ufe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ufe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ hdl/union_find_engine.sv @@
// Union-find engine: union by size with full path compression over RAM-held sets.
// Each request walks the parent links from node_a to its root, re-links every node on
//   that path to the root, does the same for node_b, then, if the roots differ, links the
//   smaller root under the larger; a request with a bad node is answered without a walk.
// Throughput: one request in flight; the next is taken no earlier than the edge that
//   takes the result.
// Reset and every node_count write start a clearing pass that rewrites each parent link
//   to itself and each size to one; no request is taken then.
`timescale 1ns / 1ps
`include "union_find_engine_assert.svh"
module union_find_engine
	import ufe_pkg::*;
#(
	parameter int MAX_NODES = UFE_MAX_NODES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [COUNT_W-1:0]    cfg_wdata,     // node_count
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // node_a [9:0], node_b [19:10]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // merged [0], set_count [11:1]
	output logic                  m_axis_tuser   // bad_node
);
	localparam int IW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_FIND, S_COMP, S_NEXT, S_SZB, S_LINK
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   clr_q;
	logic [CW-1:0]   node_count_q;
	logic [CW-1:0]   sets_left_q;
	logic [IW-1:0]   a_q, b_q, cur_q, ra_q, rb_q;
	logic            side_q;
	logic [CW-1:0]   sa_q;
	logic            out_valid_q, out_merged_q, out_bad_q;
	logic [CW-1:0]   out_count_q;

	logic [NODE_W-1:0] in_a, in_b;
	logic              in_acc, in_bad;
	logic [CW-1:0]     cfg_cnt;
	logic [IW-1:0]     root_cur, start_node, big, small_root;
	logic              swap;
	logic [CW-1:0]     sum;

	logic            p_we, p_re, s_we, s_re;
	logic [IW-1:0]   p_waddr, p_wdata, p_raddr, p_rdata, s_waddr, s_raddr;
	logic [CW-1:0]   s_wdata, s_rdata;

	assign in_a   = s_axis_tdata[NODE_W-1:0];
	assign in_b   = s_axis_tdata[2*NODE_W-1:NODE_W];
	assign in_bad = (32'(in_a) >= 32'(node_count_q)) || (32'(in_b) >= 32'(node_count_q));
	assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_acc = s_axis_tvalid && s_axis_tready;

	assign root_cur   = side_q ? rb_q : ra_q;
	assign start_node = side_q ? b_q : a_q;
	assign swap       = sa_q < s_rdata;
	assign big        = swap ? rb_q : ra_q;
	assign small_root = swap ? ra_q : rb_q;
	assign sum        = sa_q + s_rdata;

	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_cnt = CW'(1);
		end else if (32'(cfg_wdata) > MAX_NODES) begin
			cfg_cnt = CW'(MAX_NODES);
		end else begin
			cfg_cnt = CW'(cfg_wdata);
		end
	end

	// memory request steering
	always_comb begin
		p_re    = 1'b0;
		p_raddr = cur_q;
		p_we    = 1'b0;
		p_waddr = cur_q;
		p_wdata = root_cur;
		s_re    = 1'b0;
		s_raddr = ra_q;
		s_we    = 1'b0;
		s_waddr = big;
		s_wdata = sum;
		case (state_q)
			S_CLEAR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = clr_q;
				s_we    = 1'b1;
				s_waddr = clr_q;
				s_wdata = CW'(1);
			end
			S_IDLE: begin
				p_re    = in_acc && !in_bad;
				p_raddr = IW'(in_a);
			end
			S_FIND: begin
				p_re = 1'b1;
				if (p_rdata == cur_q) begin
					if (start_node != cur_q) begin
						p_raddr = start_node;
					end else if (!side_q) begin
						p_raddr = b_q;
					end else begin
						p_re = 1'b0;
						s_re = cur_q != ra_q;
					end
				end else begin
					p_raddr = p_rdata;
				end
			end
			S_COMP: begin
				p_we = 1'b1;
				if (p_rdata != root_cur) begin
					p_re    = 1'b1;
					p_raddr = p_rdata;
				end
			end
			S_NEXT: begin
				if (!side_q) begin
					p_re    = 1'b1;
					p_raddr = b_q;
				end else begin
					s_re = rb_q != ra_q;
				end
			end
			S_SZB: begin
				s_re    = 1'b1;
				s_raddr = rb_q;
			end
			S_LINK: begin
				p_we    = 1'b1;
				p_waddr = small_root;
				p_wdata = big;
				s_we    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	ufe_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_parent_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.re    (p_re),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	ufe_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_size_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			node_count_q <= CW'(MAX_NODES);
			sets_left_q  <= CW'(MAX_NODES);
			a_q          <= '0;
			b_q          <= '0;
			cur_q        <= '0;
			ra_q         <= '0;
			rb_q         <= '0;
			side_q       <= 1'b0;
			sa_q         <= '0;
			out_valid_q  <= 1'b0;
			out_merged_q <= 1'b0;
			out_bad_q    <= 1'b0;
			out_count_q  <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(MAX_NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						a_q <= IW'(in_a);
						b_q <= IW'(in_b);
						if (in_bad) begin
							out_valid_q  <= 1'b1;
							out_merged_q <= 1'b0;
							out_bad_q    <= 1'b1;
							out_count_q  <= sets_left_q;
						end else begin
							cur_q   <= IW'(in_a);
							side_q  <= 1'b0;
							state_q <= S_FIND;
						end
					end
				end
				S_FIND: begin
					if (p_rdata == cur_q) begin
						if (side_q) begin
							rb_q <= cur_q;
						end else begin
							ra_q <= cur_q;
						end
						if (start_node != cur_q) begin
							cur_q   <= start_node;
							state_q <= S_COMP;
						end else if (!side_q) begin
							cur_q  <= b_q;
							side_q <= 1'b1;
						end else if (cur_q == ra_q) begin
							out_valid_q  <= 1'b1;
							out_merged_q <= 1'b0;
							out_bad_q    <= 1'b0;
							out_count_q  <= sets_left_q;
							state_q      <= S_IDLE;
						end else begin
							state_q <= S_SZB;
						end
					end else begin
						cur_q <= p_rdata;
					end
				end
				S_COMP: begin
					if (p_rdata == root_cur) begin
						state_q <= S_NEXT;
					end else begin
						cur_q <= p_rdata;
					end
				end
				// bubble so the next walk never reads an entry written this cycle
				S_NEXT: begin
					if (!side_q) begin
						cur_q   <= b_q;
						side_q  <= 1'b1;
						state_q <= S_FIND;
					end else if (rb_q == ra_q) begin
						out_valid_q  <= 1'b1;
						out_merged_q <= 1'b0;
						out_bad_q    <= 1'b0;
						out_count_q  <= sets_left_q;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_SZB;
					end
				end
				S_SZB: begin
					sa_q    <= s_rdata;
					state_q <= S_LINK;
				end
				S_LINK: begin
					out_valid_q  <= 1'b1;
					out_merged_q <= 1'b1;
					out_bad_q    <= 1'b0;
					if (sets_left_q != '0) begin
						sets_left_q <= sets_left_q - 1'b1;
						out_count_q <= sets_left_q - 1'b1;
					end else begin
						out_count_q <= sets_left_q;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we) begin
				node_count_q <= cfg_cnt;
				sets_left_q  <= cfg_cnt;
				clr_q        <= '0;
				state_q      <= S_CLEAR;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, COUNT_W'(out_count_q), out_merged_q};
	assign m_axis_tuser  = out_bad_q;

	`UFE_NEVER(no_accept_while_stalled, in_acc && m_axis_tvalid && !m_axis_tready)
	`UFE_NEVER(parent_rw_same_entry, p_we && p_re && (p_waddr == p_raddr))
	`UFE_NEVER(sets_left_range, (sets_left_q == '0) || (sets_left_q > node_count_q))
	`UFE_ASSERT(sets_left_step, !cfg_we |=> ($past(sets_left_q) - sets_left_q) <= CW'(1))
endmodule

@@ dv/tb_union_find_engine.sv @@
// Testbench for union_find_engine: directed and random union requests checked against a DSU model.
`timescale 1ns / 1ps
module tb_union_find_engine
	import ufe_pkg::*;
();

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic               merged;
		logic [COUNT_W-1:0] set_count;
		logic               bad_node;
	} union_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [COUNT_W-1:0]    cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // node_a, node_b, zero pad
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // merged, set_count, zero pad
	logic                  m_axis_tuser;   // bad_node

	// disjoint-set model state
	int unsigned   dsu_parent [UFE_MAX_NODES];
	int unsigned   dsu_size [UFE_MAX_NODES];
	int unsigned   dsu_nodes;
	int unsigned   dsu_sets;
	union_result_t pending_results [$];

	int  mismatches = 0;
	int  stall_cycles = 0;
	bit  quiet;

	union_find_engine DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void clear_sets(int unsigned count);
		for (int i = 0; i < UFE_MAX_NODES; i++) begin
			dsu_parent[i] = i;
			dsu_size[i]   = 1;
		end
		dsu_nodes = count;
		dsu_sets  = count;
	endfunction

	// walk to the root, then relink every node on the path straight to it
	function automatic int unsigned find_root(int unsigned v);
		int unsigned r;
		int unsigned nxt;
		r = v;
		while (dsu_parent[r] != r)
			r = dsu_parent[r];
		while (v != r) begin
			nxt = dsu_parent[v];
			dsu_parent[v] = r;
			v = nxt;
		end
		return r;
	endfunction

	function automatic union_result_t join_sets(int unsigned a, int unsigned b);
		union_result_t res;
		int unsigned   ra;
		int unsigned   rb;
		int unsigned   t;
		res = '0;
		if (a >= dsu_nodes || b >= dsu_nodes) begin
			res.set_count = COUNT_W'(dsu_sets);
			res.bad_node  = 1'b1;
			return res;
		end
		ra = find_root(a);
		rb = find_root(b);
		if (ra != rb) begin
			// tie keeps node_a's root on top
			if (dsu_size[ra] < dsu_size[rb]) begin
				t  = ra;
				ra = rb;
				rb = t;
			end
			dsu_parent[rb] = ra;
			dsu_size[ra] += dsu_size[rb];
			if (dsu_sets > 0)
				dsu_sets--;
			res.merged = 1'b1;
		end
		res.set_count = COUNT_W'(dsu_sets);
		return res;
	endfunction

	task automatic report_mismatch(string field, int got, int exp_val);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, exp_val);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin
		union_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", int'(m_axis_tdata), -1);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[0] !== want.merged)
					report_mismatch("merged", int'(m_axis_tdata[0]), int'(want.merged));
				if (m_axis_tdata[COUNT_W:1] !== want.set_count)
					report_mismatch("set_count", int'(m_axis_tdata[COUNT_W:1]),
						int'(want.set_count));
				if (m_axis_tuser !== want.bad_node)
					report_mismatch("bad_node", int'(m_axis_tuser), int'(want.bad_node));
			end
		end
	end

	// result-side backpressure
	always @(posedge clk)
		m_axis_tready <= quiet || ($urandom_range(99) >= 12);

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_union_find_engine NOT OK");
			$finish;
		end
	end

	task automatic send_request(int unsigned a, int unsigned b);
		while (!quiet && $urandom_range(99) < 12) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{IN_PAD_W{1'b0}}, b[NODE_W-1:0], a[NODE_W-1:0]};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(join_sets(a, b));
	endtask

	// stop sending and wait for every outstanding result
	task automatic hold_requests();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_node_count(int unsigned value);
		int unsigned v;
		hold_requests();
		cfg_we    <= 1'b1;
		cfg_wdata <= value[COUNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		v = value & 11'h7FF;
		if (v == 0)
			v = 1;
		if (v > UFE_MAX_NODES)
			v = UFE_MAX_NODES;
		clear_sets(v);
	endtask

	function automatic int unsigned pick_node();
		if ($urandom_range(99) < 88)
			return $urandom_range(dsu_nodes - 1);
		return $urandom_range(UFE_MAX_NODES - 1);
	endfunction

	task automatic test_default_range();
		send_request(0, 0);
		send_request(1023, 0);
		send_request(0, 1023);
		send_request(512, 341);
		send_request(682, 1);
		send_request(512, 682);
	endtask

	task automatic test_count_saturation();
		write_node_count(0);
		send_request(0, 0);
		send_request(0, 1);
		send_request(1023, 1023);
		write_node_count(2047);
		send_request(1023, 1022);
		write_node_count(1025);
		send_request(1023, 0);
	endtask

	task automatic test_path_compression();
		write_node_count(16);
		send_request(0, 1);
		send_request(2, 3);
		send_request(0, 2);
		send_request(4, 5);
		send_request(6, 7);
		send_request(4, 6);
		send_request(3, 7);
		send_request(7, 1);
		send_request(15, 14);
		send_request(15, 0);
		send_request(16, 0);
		send_request(0, 1023);
	endtask

	task automatic test_random_unions();
		int unsigned counts [6] = '{2, 7, 64, 1024, 333, 1000};
		int          lens [6]   = '{40, 60, 100, 120, 80, 50};
		for (int p = 0; p < 6; p++) begin
			write_node_count(counts[p]);
			quiet = (p == 3);
			for (int i = 0; i < lens[p]; i++) begin
				if (p == 2 && i == lens[p] / 2)
					hold_requests();
				send_request(pick_node(), pick_node());
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		quiet         = 1'b0;
		clear_sets(UFE_MAX_NODES);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_default_range();
		test_count_saturation();
		test_path_compression();
		test_random_unions();

		hold_requests();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_union_find_engine OK");
		else
			$display("tb_union_find_engine NOT OK");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+hdl
hdl/ufe_pkg.sv
hdl/ufe_ram.sv
hdl/union_find_engine.sv
dv/tb_union_find_engine.sv
